FILE: design/mcavg_pkg.sv
// ----------------------------------------------------------------------------
// mcavg_pkg
// Shared widths and constants for the multichannel moving average block.
// ----------------------------------------------------------------------------
package mcavg_pkg;

  // Field widths fixed by the sample and result formats.
  localparam int SAMPLE_W   = 10;
  localparam int CHAN_IDX_W = 2;
  localparam int COUNT_W    = 16;

  // Saturation limits and the reset value of the start count register.
  localparam logic [SAMPLE_W-1:0] VALUE_MAX   = 10'd1023;
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = 16'hFFFF;
  localparam logic [COUNT_W-1:0]  START_RESET = 16'd36;

  // Input mode codes.
  localparam logic MODE_SAMPLE      = 1'b0;
  localparam logic MODE_CLEAR_EXTREMES = 1'b1;

endpackage

FILE: design/multichannel_moving_average_min_max_core.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average_min_max_core
// Per-channel boxcar moving average of converter samples, with running
// minimum and maximum of the average, kept in two synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
// Input words (mode, channel_index, sample_value) arrive on in_valid/in_ready
// and each produces one output word on out_valid/out_ready carrying the
// channel's average, minimum, maximum and a flag that the sample was stored.
// The first CHANNELS conversions after reset are counted but not stored.
// Mode 1 clears every channel's minimum to 1023 and maximum to 0.
// The start count register is written through cfg_write_en/cfg_write_data;
// the user must write it only while the block is idle, which the block does
// not enforce. It resets to 36. A word passes stage one and then the output
// register, which drives out_valid. One word is accepted every cycle while
// the output is not stalled: the sample ring and the channel state memory are
// read in the cycle of acceptance and written back as the word leaves stage
// one, with fresh state forwarded to a following word for the same channel.
// An output register decouples the two sides; when the receiver stalls, the
// output register holds, stage one takes at most one more word, and in_ready
// is low for as long as both are full and out_ready stays low.
// Reset is synchronous. Per-channel valid bits stand in for the cleared
// memories, so no clearing pass is needed and words are taken at once.
// ----------------------------------------------------------------------------
module multichannel_moving_average_min_max_core #(
  parameter int CHANNELS      = 4,
  parameter int RING_DEPTH    = 8,
  parameter int AVERAGE_SHIFT = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              cfg_write_en,
  input  logic [mcavg_pkg::COUNT_W-1:0]     cfg_write_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [mcavg_pkg::CHAN_IDX_W-1:0]  channel_index,
  input  logic [mcavg_pkg::SAMPLE_W-1:0]    sample_value,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mcavg_pkg::SAMPLE_W-1:0]    average_value,
  output logic [mcavg_pkg::SAMPLE_W-1:0]    minimum_value,
  output logic [mcavg_pkg::SAMPLE_W-1:0]    maximum_value,
  output logic                              sample_taken
);
  import mcavg_pkg::*;

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W      = $clog2(RING_DEPTH);
  localparam int RING_WORDS = CHANNELS << POS_W;
  localparam int SUM_W      = SAMPLE_W + POS_W;
  localparam int CHAN_W     = SUM_W + 3 * SAMPLE_W;

  // Channel state word layout: sum, average, minimum, maximum.
  localparam int MAX_LO = 0;
  localparam int MIN_LO = SAMPLE_W;
  localparam int AVG_LO = 2 * SAMPLE_W;
  localparam int SUM_LO = 3 * SAMPLE_W;

  // Memories.
  logic [SAMPLE_W-1:0] ring_mem [RING_WORDS];
  logic [CHAN_W-1:0]   chan_mem [CHANNELS];

  // Per-channel control state.
  logic [POS_W-1:0]    pos [CHANNELS];
  logic [CHANNELS-1:0] wrapped;
  logic [CHANNELS-1:0] chv;
  logic [CHANNELS-1:0] exv;
  logic [COUNT_W-1:0]  conversion_total;
  logic [COUNT_W-1:0]  average_start_count;

  // Stage one registers.
  logic                s1_valid;
  logic [CH_W-1:0]     s1_ch;
  logic [POS_W-1:0]    s1_pos;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_mode;
  logic                s1_in_range;
  logic                s1_taken;
  logic                s1_update;
  logic                s1_old_ok;
  logic                s1_chv;
  logic                s1_exv;
  logic                s1_byp;
  logic [SUM_W-1:0]    byp_sum;
  logic [SAMPLE_W-1:0] byp_avg;
  logic [SAMPLE_W-1:0] byp_min;
  logic [SAMPLE_W-1:0] byp_max;
  logic [SAMPLE_W-1:0] ring_rd_data;
  logic [CHAN_W-1:0]   chan_rd_data;
  logic                out_updated;

  // Combinational signals.
  logic                in_fire;
  logic                in_range;
  logic [CH_W-1:0]     in_ch;
  logic [POS_W-1:0]    in_pos;
  logic                in_taken;
  logic                in_update;
  logic                s1_go;
  logic                s1_fire;
  logic                s1_write;
  logic [SUM_W-1:0]    cur_sum;
  logic [SAMPLE_W-1:0] cur_avg;
  logic [SAMPLE_W-1:0] cur_min;
  logic [SAMPLE_W-1:0] cur_max;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    new_sum;
  logic [SUM_W-1:0]    avg_raw;
  logic [SAMPLE_W-1:0] new_avg;
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] avg_next;
  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] max_next;

  // Handshake: stage one moves on when the output register is free.
  assign s1_go    = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_go;
  assign s1_write = s1_fire && s1_taken;
  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;

  // Input decode: warm-up and averaging start use the count before this word.
  always_comb begin
    in_range  = 32'(channel_index) < CHANNELS;
    in_ch     = CH_W'(channel_index);
    in_pos    = in_range ? pos[in_ch] : '0;
    in_taken  = (mode == MODE_SAMPLE) && in_range &&
                (conversion_total >= COUNT_W'(CHANNELS));
    in_update = in_taken && (conversion_total >= average_start_count);
  end

  // Memory reads in the cycle of acceptance; they hold while stage one stalls.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring_rd_data <= ring_mem[{in_ch, in_pos}];
      chan_rd_data <= chan_mem[in_ch];
    end
  end

  // Write back of the stored sample and the channel state.
  always_ff @(posedge clk) begin
    if (s1_write) begin
      ring_mem[{s1_ch, s1_pos}] <= s1_sample;
      chan_mem[s1_ch]           <= {sum_next, avg_next, min_next, max_next};
    end
  end

  // Current channel state: forwarded from the word ahead, or from memory
  // with never-written and cleared entries read as their reset values.
  always_comb begin
    if (s1_byp) begin
      cur_sum = byp_sum;
      cur_avg = byp_avg;
      cur_min = byp_min;
      cur_max = byp_max;
    end else begin
      cur_sum = s1_chv ? chan_rd_data[SUM_LO +: SUM_W] : '0;
      cur_avg = s1_chv ? chan_rd_data[AVG_LO +: SAMPLE_W] : '0;
      cur_min = s1_exv ? chan_rd_data[MIN_LO +: SAMPLE_W] : VALUE_MAX;
      cur_max = s1_exv ? chan_rd_data[MAX_LO +: SAMPLE_W] : '0;
    end
  end

  // Running sum, saturated average and extremes update.
  always_comb begin
    old_sample = s1_old_ok ? ring_rd_data : '0;
    new_sum    = cur_sum - SUM_W'(old_sample) + SUM_W'(s1_sample);
    avg_raw    = new_sum >> AVERAGE_SHIFT;
    new_avg    = (avg_raw > SUM_W'(VALUE_MAX)) ? VALUE_MAX : avg_raw[SAMPLE_W-1:0];
    sum_next   = s1_taken ? new_sum : cur_sum;
    avg_next   = cur_avg;
    min_next   = cur_min;
    max_next   = cur_max;
    if (s1_update) begin
      avg_next = new_avg;
      min_next = (new_avg < cur_min) ? new_avg : cur_min;
      max_next = (new_avg > cur_max) ? new_avg : cur_max;
    end
  end

  // Stage one register and forwarding capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch       <= in_ch;
      s1_pos      <= in_pos;
      s1_sample   <= sample_value;
      s1_mode     <= mode;
      s1_in_range <= in_range;
      s1_taken    <= in_taken;
      s1_update   <= in_update;
      s1_old_ok   <= in_range && wrapped[in_ch];
      s1_chv      <= in_range && chv[in_ch];
      s1_exv      <= in_range && exv[in_ch];
      s1_byp      <= s1_write && (s1_ch == in_ch);
      byp_sum     <= sum_next;
      byp_avg     <= avg_next;
      byp_min     <= min_next;
      byp_max     <= max_next;
    end
  end

  // Control state: ring pointers, valid bits, conversion count, register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos[c] <= '0;
      end
      wrapped             <= '0;
      chv                 <= '0;
      exv                 <= '0;
      conversion_total    <= '0;
      average_start_count <= START_RESET;
    end else begin
      if (cfg_write_en) begin
        average_start_count <= cfg_write_data;
      end
      if (s1_write) begin
        chv[s1_ch] <= 1'b1;
        exv[s1_ch] <= 1'b1;
      end
      if (in_fire && in_taken) begin
        if (in_pos == POS_W'(RING_DEPTH - 1)) begin
          pos[in_ch]     <= '0;
          wrapped[in_ch] <= 1'b1;
        end else begin
          pos[in_ch] <= in_pos + POS_W'(1);
        end
      end
      if (in_fire && (mode == MODE_SAMPLE) && (conversion_total != COUNT_MAX)) begin
        conversion_total <= conversion_total + COUNT_W'(1);
      end
      // A clear of the extremes overrides a write back at the same edge.
      if (in_fire && (mode == MODE_CLEAR_EXTREMES)) begin
        exv <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_updated <= s1_update;
      sample_taken <= s1_taken;
      if (!s1_in_range) begin
        average_value <= '0;
        minimum_value <= '0;
        maximum_value <= '0;
      end else if (s1_mode == MODE_CLEAR_EXTREMES) begin
        average_value <= avg_next;
        minimum_value <= VALUE_MAX;
        maximum_value <= '0;
      end else begin
        average_value <= avg_next;
        minimum_value <= min_next;
        maximum_value <= max_next;
      end
    end
  end

  // The conversion count only ever grows.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (conversion_total >= $past(conversion_total)))
    else $error("conversion count decreased");

  // An updated average lies between the reported extremes.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_updated) |->
      ((minimum_value <= average_value) && (average_value <= maximum_value)))
    else $error("average outside its minimum and maximum");

  // A clear of the extremes leaves every channel without extremes.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && (mode == MODE_CLEAR_EXTREMES)) |=> (exv == '0))
    else $error("extremes not cleared");

  // Read data of a stalled word must not be disturbed.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> ($stable(ring_rd_data) && $stable(chan_rd_data)))
    else $error("memory read data changed under a stalled word");

endmodule
